### hw/rtl/kv_text_reply_parser_unit_assert.svh
// assertion macros shared by the checker
`ifndef KV_TEXT_REPLY_PARSER_UNIT_ASSERT_SVH
`define KV_TEXT_REPLY_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define KVRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KVRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/kvrp_pkg.sv
`timescale 1ns / 1ps
package kvrp_pkg;

    localparam int OFFSET_BITS_DEF = 32;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [63:0] M32 = 64'h0000_0000_FFFF_FFFF;

    // keyword candidates
    localparam int KW_VALUE      = 0;
    localparam int KW_END        = 1;
    localparam int KW_STORED     = 2;
    localparam int KW_NOT_STORED = 3;
    localparam int KW_DELETED    = 4;
    localparam int KW_NOT_FOUND  = 5;
    localparam int KW_ERROR      = 6;
    localparam int KW_CLIENT     = 7;
    localparam int KW_SERVER     = 8;
    localparam int KW_DIGITS     = 9;
    localparam int NUM_KW        = 9;

    localparam logic [9:0] KM_ALL = 10'h3FF;

    localparam logic [95:0] KW_TEXT [NUM_KW] = '{
        96'("VALUE "), 96'("END"), 96'("STORED"), 96'({"NOT_", "STORED"}),
        96'("DELETED"), 96'({"NOT_", "FOUND"}), 96'("ERROR"),
        96'({"CLIENT_", "ERROR"}), 96'({"SERVER_", "ERROR"})
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd6, 4'd3, 4'd6, 4'd10, 4'd7, 4'd9, 4'd5, 4'd12, 4'd12
    };
    localparam logic [NUM_KW-1:0] KW_PREFIX = 9'b110000001;

    // reply types
    localparam logic [3:0] RT_END        = 4'd0;
    localparam logic [3:0] RT_VALUE      = 4'd1;
    localparam logic [3:0] RT_SERVER_ERR = 4'd6;
    localparam logic [3:0] RT_CLIENT_ERR = 4'd7;
    localparam logic [3:0] RT_COUNTER    = 4'd8;

    typedef enum logic [2:0] {
        PH_FIRST, PH_GETLINE, PH_DATA, PH_TRAIL1, PH_TRAIL2
    } t_phase;

    // header field being parsed
    localparam logic [1:0] HF_KEY   = 2'd0;
    localparam logic [1:0] HF_FLAGS = 2'd1;
    localparam logic [1:0] HF_BYTES = 2'd2;
    localparam logic [1:0] HF_REST  = 2'd3;

    typedef struct packed {
        logic [9:0]  km;
        logic [1:0]  hf;
        logic [63:0] acc;
    } t_scan;

    localparam t_scan SCAN_RST = '{km: KM_ALL, hf: HF_KEY, acc: 64'd0};

    typedef struct packed {
        logic        key_we;
        logic        flags_we;
        logic [31:0] flags;
    } t_cap;

    typedef struct packed {
        logic        status;
        logic [3:0]  reply_type;
        logic [31:0] consumed_len;
        logic [31:0] key_offset;
        logic [31:0] key_len;
        logic [31:0] item_flags;
        logic [31:0] data_offset;
        logic [31:0] data_len;
        logic [63:0] counter_value;
        logic [31:0] msg_offset;
        logic [31:0] msg_len;
    } t_result;

    // character i of keyword k, zero past its end
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
        logic [95:0] t;
        logic [3:0]  sh;
        t  = KW_TEXT[k];
        sh = KW_LEN[k] - 4'd1 - i;
        if (i >= KW_LEN[k]) begin
            return 8'd0;
        end
        return t[{sh, 3'b000} +: 8];
    endfunction

endpackage

### hw/rtl/kvrp_scan.sv
`timescale 1ns / 1ps
// one line-content byte: keyword match, header fields, decimal accumulator
module kvrp_scan #(
    parameter int OFFSET_BITS = kvrp_pkg::OFFSET_BITS_DEF
) (
    input  logic [7:0]             i_c,
    input  kvrp_pkg::t_scan        i_st,
    input  logic [OFFSET_BITS-1:0] i_len,
    input  logic                   i_got,
    output kvrp_pkg::t_scan        o_st,
    output logic [OFFSET_BITS-1:0] o_len,
    output kvrp_pkg::t_cap         o_cap
);

    logic        digit;
    logic        space;
    logic [3:0]  dval;
    logic [63:0] prod;

    assign digit = (i_c >= kvrp_pkg::CH_ZERO) && (i_c <= kvrp_pkg::CH_NINE);
    assign space = (i_c == kvrp_pkg::CH_SPACE);
    assign dval  = 4'(i_c - kvrp_pkg::CH_ZERO);
    assign prod  = (i_st.acc << 3) + (i_st.acc << 1) + {60'd0, dval};

    always_comb begin
        o_st  = i_st;
        o_cap = '0;
        for (int k = 0; k < kvrp_pkg::NUM_KW; k++) begin
            if (o_st.km[k]) begin
                if (i_len < OFFSET_BITS'(kvrp_pkg::KW_LEN[k])) begin
                    if (i_c != kvrp_pkg::kw_char(k, i_len[3:0])) begin
                        o_st.km[k] = 1'b0;
                    end
                end else if (!kvrp_pkg::KW_PREFIX[k]) begin
                    o_st.km[k] = 1'b0;
                end
            end
        end
        if (o_st.km[kvrp_pkg::KW_DIGITS]) begin
            if (digit) begin
                o_st.acc = prod;
            end else begin
                o_st.km[kvrp_pkg::KW_DIGITS] = 1'b0;
            end
        end
        // space after CLIENT_ERROR or SERVER_ERROR (byte index 12) marks a message
        if (!o_st.km[kvrp_pkg::KW_VALUE] && i_len == OFFSET_BITS'(12) && space) begin
            o_st.hf = kvrp_pkg::HF_FLAGS;
        end
        o_cap.flags = i_st.acc[31:0];
        if (o_st.km[kvrp_pkg::KW_VALUE] && i_len >= OFFSET_BITS'(6)) begin
            unique case (o_st.hf)
                kvrp_pkg::HF_KEY: begin
                    if (space) begin
                        if (i_len == OFFSET_BITS'(6)) begin
                            o_st.km[kvrp_pkg::KW_VALUE] = 1'b0;
                        end else begin
                            o_cap.key_we = !i_got;
                        end
                        o_st.hf  = kvrp_pkg::HF_FLAGS;
                        o_st.acc = 64'd0;
                    end
                end
                kvrp_pkg::HF_FLAGS: begin
                    if (space) begin
                        o_cap.flags_we = !i_got;
                        o_st.hf  = kvrp_pkg::HF_BYTES;
                        o_st.acc = 64'd0;
                    end else if (digit) begin
                        o_st.acc = {32'd0, prod[31:0]};
                    end else begin
                        o_st.km[kvrp_pkg::KW_VALUE] = 1'b0;
                    end
                end
                kvrp_pkg::HF_BYTES: begin
                    if (space) begin
                        o_st.hf = kvrp_pkg::HF_REST;
                    end else if (digit) begin
                        // saturate just above 32 bits
                        o_st.acc = (prod > kvrp_pkg::M32) ? kvrp_pkg::M32 + 64'd1 : prod;
                    end else begin
                        o_st.km[kvrp_pkg::KW_VALUE] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        o_len = (i_len == '1) ? i_len : i_len + OFFSET_BITS'(1);
    end

endmodule

### hw/rtl/kvrp_core.sv
`timescale 1ns / 1ps
// reply state machine, line end decode and result formation
module kvrp_core #(
    parameter int OFFSET_BITS = kvrp_pkg::OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_restart,
    output logic              o_res_vld,
    output kvrp_pkg::t_result o_res
);

    localparam int OW = OFFSET_BITS;

    kvrp_pkg::t_phase r_phase, n_phase, e_phase;
    logic [OW-1:0]   r_pos, n_pos, e_pos;
    logic [OW-1:0]   r_len, n_len, e_len;
    kvrp_pkg::t_scan r_st, n_st, e_st;
    logic            r_cr, n_cr, e_cr;
    logic [31:0]     r_drem, n_drem, e_drem;
    logic            r_got, n_got, e_got;
    logic [OW-1:0]   r_cap5, n_cap5, e_cap5;
    logic            r_bad, n_bad, e_bad;
    logic            r_halt, n_halt, e_halt;

    logic [OW-1:0]   r_koff, n_koff;
    logic [OW-1:0]   r_klen, n_klen;
    logic [31:0]     r_flags, n_flags;
    logic [OW-1:0]   r_doff, n_doff;
    logic [31:0]     r_dlen, n_dlen;

    kvrp_pkg::t_scan a_st, b_in_st, b_st;
    logic [OW-1:0]   a_len, b_in_len, b_len;
    kvrp_pkg::t_cap  a_cap, b_cap;

    logic [OW-1:0]   posp1;
    logic            sp, is_value, emit, fail;

    // pending CR folded in as content first
    kvrp_scan #(.OFFSET_BITS(OW)) u_scan_cr (
        .i_c(kvrp_pkg::CH_CR), .i_st(e_st), .i_len(e_len), .i_got(e_got),
        .o_st(a_st), .o_len(a_len), .o_cap(a_cap)
    );

    assign b_in_st  = e_cr ? a_st : e_st;
    assign b_in_len = e_cr ? a_len : e_len;

    kvrp_scan #(.OFFSET_BITS(OW)) u_scan_byte (
        .i_c(i_byte), .i_st(b_in_st), .i_len(b_in_len), .i_got(e_got),
        .o_st(b_st), .o_len(b_len), .o_cap(b_cap)
    );

    always_comb begin
        e_phase = i_restart ? kvrp_pkg::PH_FIRST : r_phase;
        e_pos   = i_restart ? '0 : r_pos;
        e_len   = i_restart ? '0 : r_len;
        e_st    = i_restart ? kvrp_pkg::SCAN_RST : r_st;
        e_cr    = i_restart ? 1'b0 : r_cr;
        e_drem  = i_restart ? 32'd0 : r_drem;
        e_got   = i_restart ? 1'b0 : r_got;
        e_cap5  = i_restart ? '0 : r_cap5;
        e_bad   = i_restart ? 1'b0 : r_bad;
        e_halt  = i_restart ? 1'b0 : r_halt;

        n_phase = e_phase;
        n_pos   = e_pos;
        n_len   = e_len;
        n_st    = e_st;
        n_cr    = e_cr;
        n_drem  = e_drem;
        n_got   = e_got;
        n_cap5  = e_cap5;
        n_bad   = e_bad;
        n_halt  = e_halt;
        n_koff  = r_koff;
        n_klen  = r_klen;
        n_flags = r_flags;
        n_doff  = r_doff;
        n_dlen  = r_dlen;

        posp1 = e_pos + OW'(1);
        sp    = (e_st.hf == kvrp_pkg::HF_FLAGS) && (e_len > OW'(13));
        is_value = e_st.km[kvrp_pkg::KW_VALUE] && (e_len >= OW'(11))
                   && (e_st.hf >= kvrp_pkg::HF_BYTES) && (e_st.acc <= kvrp_pkg::M32);
        emit  = 1'b0;
        fail  = 1'b0;
        o_res = '0;
        o_res.consumed_len = 32'(posp1);

        if (i_step && !e_halt) begin
            n_pos = posp1;
            unique case (e_phase)
                kvrp_pkg::PH_DATA: begin
                    n_drem = (e_drem != 32'd0) ? e_drem - 32'd1 : 32'd0;
                    if (n_drem == 32'd0) begin
                        n_phase = kvrp_pkg::PH_TRAIL1;
                    end
                end
                kvrp_pkg::PH_TRAIL1: begin
                    n_bad   = (i_byte != kvrp_pkg::CH_CR);
                    n_phase = kvrp_pkg::PH_TRAIL2;
                end
                kvrp_pkg::PH_TRAIL2: begin
                    if (e_bad || i_byte != kvrp_pkg::CH_LF) begin
                        fail = 1'b1;
                    end else begin
                        n_bad   = 1'b0;
                        n_phase = kvrp_pkg::PH_GETLINE;
                        n_len   = '0;
                        n_st    = kvrp_pkg::SCAN_RST;
                        n_cr    = 1'b0;
                        n_cap5  = posp1;
                    end
                end
                kvrp_pkg::PH_FIRST, kvrp_pkg::PH_GETLINE: begin
                    if (e_cr && i_byte == kvrp_pkg::CH_LF) begin
                        // line end
                        priority if (e_st.km[kvrp_pkg::KW_END] && e_len == OW'(3)) begin
                            emit = 1'b1;
                            if (e_got) begin
                                o_res.reply_type  = kvrp_pkg::RT_VALUE;
                                o_res.key_offset  = 32'(r_koff);
                                o_res.key_len     = 32'(r_klen);
                                o_res.item_flags  = r_flags;
                                o_res.data_offset = 32'(r_doff);
                                o_res.data_len    = r_dlen;
                            end else begin
                                o_res.reply_type  = kvrp_pkg::RT_END;
                            end
                        end else if (is_value) begin
                            if (!e_got) begin
                                n_doff = posp1;
                                n_dlen = e_st.acc[31:0];
                                n_got  = 1'b1;
                            end
                            n_drem  = e_st.acc[31:0];
                            n_phase = (e_st.acc == 64'd0) ? kvrp_pkg::PH_TRAIL1
                                                          : kvrp_pkg::PH_DATA;
                            n_len   = '0;
                            n_st    = kvrp_pkg::SCAN_RST;
                            n_cr    = 1'b0;
                            n_cap5  = '0;
                        end else if (e_phase != kvrp_pkg::PH_FIRST) begin
                            fail = 1'b1;
                        end else begin
                            emit = 1'b1;
                            priority if (e_st.km[kvrp_pkg::KW_STORED]
                                         && e_len == OW'(6)) begin
                                o_res.reply_type = 4'(kvrp_pkg::KW_STORED);
                            end else if (e_st.km[kvrp_pkg::KW_NOT_STORED]
                                         && e_len == OW'(10)) begin
                                o_res.reply_type = 4'(kvrp_pkg::KW_NOT_STORED);
                            end else if (e_st.km[kvrp_pkg::KW_DELETED]
                                         && e_len == OW'(7)) begin
                                o_res.reply_type = 4'(kvrp_pkg::KW_DELETED);
                            end else if (e_st.km[kvrp_pkg::KW_NOT_FOUND]
                                         && e_len == OW'(9)) begin
                                o_res.reply_type = 4'(kvrp_pkg::KW_NOT_FOUND);
                            end else if (e_st.km[kvrp_pkg::KW_ERROR]
                                         && e_len == OW'(5)) begin
                                o_res.reply_type = kvrp_pkg::RT_SERVER_ERR;
                                o_res.msg_offset = 32'(e_len);
                            end else if ((e_st.km[kvrp_pkg::KW_CLIENT]
                                          || e_st.km[kvrp_pkg::KW_SERVER])
                                         && e_len >= OW'(12)) begin
                                o_res.reply_type = e_st.km[kvrp_pkg::KW_CLIENT]
                                                   ? kvrp_pkg::RT_CLIENT_ERR
                                                   : kvrp_pkg::RT_SERVER_ERR;
                                o_res.msg_offset = sp ? 32'd13 : 32'(e_len);
                                o_res.msg_len    = sp ? 32'(e_len - OW'(13)) : 32'd0;
                            end else if (e_st.km[kvrp_pkg::KW_DIGITS]
                                         && e_len != '0) begin
                                o_res.reply_type    = kvrp_pkg::RT_COUNTER;
                                o_res.counter_value = e_st.acc;
                            end else begin
                                emit = 1'b0;
                                fail = 1'b1;
                            end
                        end
                    end else begin
                        n_cr  = (i_byte == kvrp_pkg::CH_CR);
                        n_st  = n_cr ? b_in_st : b_st;
                        n_len = n_cr ? b_in_len : b_len;
                        if (!n_cr && b_cap.key_we) begin
                            n_koff = e_cap5 + OW'(6);
                            n_klen = b_in_len - OW'(6);
                        end
                        if (!n_cr && b_cap.flags_we) begin
                            n_flags = b_cap.flags;
                        end
                        if (e_cr && a_cap.flags_we) begin
                            n_flags = a_cap.flags;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (fail) begin
            o_res = '0;
            o_res.status       = 1'b1;
            o_res.consumed_len = 32'(posp1);
        end
        o_res_vld = emit || fail;
        if (emit || fail) begin
            n_phase = kvrp_pkg::PH_FIRST;
            n_pos   = '0;
            n_len   = '0;
            n_st    = kvrp_pkg::SCAN_RST;
            n_cr    = 1'b0;
            n_drem  = 32'd0;
            n_got   = 1'b0;
            n_cap5  = '0;
            n_bad   = 1'b0;
            n_halt  = fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= kvrp_pkg::PH_FIRST;
            r_pos   <= '0;
            r_len   <= '0;
            r_st    <= kvrp_pkg::SCAN_RST;
            r_cr    <= 1'b0;
            r_drem  <= 32'd0;
            r_got   <= 1'b0;
            r_cap5  <= '0;
            r_bad   <= 1'b0;
            r_halt  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_st    <= n_st;
            r_cr    <= n_cr;
            r_drem  <= n_drem;
            r_got   <= n_got;
            r_cap5  <= n_cap5;
            r_bad   <= n_bad;
            r_halt  <= n_halt;
        end
    end

    // first value block fields, read only once got is set
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_koff  <= n_koff;
            r_klen  <= n_klen;
            r_flags <= n_flags;
            r_doff  <= n_doff;
            r_dlen  <= n_dlen;
        end
    end

endmodule

### hw/rtl/kv_text_reply_parser_unit.sv
// an accepted byte is registered in the input stage; its result is registered in the output stage
// throughput: one byte per cycle while the result side takes results
// the per-byte state update is one pass through the line scanner and decoder
// reset: synchronous active-low i_rst_n clears parser state and both stage valids
// no clearing pass: the block takes bytes in the first cycle after reset
`timescale 1ns / 1ps
module kv_text_reply_parser_unit #(
    parameter int OFFSET_BITS = kvrp_pkg::OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [3:0]  o_reply_type,
    output logic [31:0] o_consumed_len,
    output logic [31:0] o_key_offset,
    output logic [31:0] o_key_len,
    output logic [31:0] o_item_flags,
    output logic [31:0] o_data_offset,
    output logic [31:0] o_data_len,
    output logic [63:0] o_counter_value,
    output logic [31:0] o_msg_offset,
    output logic [31:0] o_msg_len
);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_in_rst;
    logic              r_out_vld;
    kvrp_pkg::t_result r_out;
    logic              adv, step, res_vld;
    kvrp_pkg::t_result res;

    assign adv        = !r_out_vld || i_out_ready;
    assign step       = r_in_vld && adv;
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_rst  <= i_restart;
        end
    end

    kvrp_core #(.OFFSET_BITS(OFFSET_BITS)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step),
        .i_byte(r_in_byte), .i_restart(r_in_rst),
        .o_res_vld(res_vld), .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= step && res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_vld) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out.status;
    assign o_reply_type    = r_out.reply_type;
    assign o_consumed_len  = r_out.consumed_len;
    assign o_key_offset    = r_out.key_offset;
    assign o_key_len       = r_out.key_len;
    assign o_item_flags    = r_out.item_flags;
    assign o_data_offset   = r_out.data_offset;
    assign o_data_len      = r_out.data_len;
    assign o_counter_value = r_out.counter_value;
    assign o_msg_offset    = r_out.msg_offset;
    assign o_msg_len       = r_out.msg_len;

endmodule

### hw/rtl/kvrp_checker.sv
`timescale 1ns / 1ps
`include "kv_text_reply_parser_unit_assert.svh"
module kvrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_in_byte,
    input logic        i_restart,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_status,
    input logic [3:0]  o_reply_type,
    input logic [31:0] o_consumed_len,
    input logic [31:0] o_key_offset,
    input logic [31:0] o_key_len,
    input logic [31:0] o_item_flags,
    input logic [31:0] o_data_offset,
    input logic [31:0] o_data_len,
    input logic [63:0] o_counter_value,
    input logic [31:0] o_msg_offset,
    input logic [31:0] o_msg_len
);

    `KVRP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_consumed_len) && $stable(o_reply_type), "stalled result changed")
    `KVRP_ASSERT_NOW(a_err_clean, o_out_valid && o_status, o_reply_type == kvrp_pkg::RT_END && o_key_len == 32'd0 && o_counter_value == 64'd0 && o_msg_offset == 32'd0, "error item carries fields")
    `KVRP_ASSERT_NOW(a_counter_only, o_out_valid && o_reply_type != kvrp_pkg::RT_COUNTER, o_counter_value == 64'd0, "counter value on non-counter item")
    `KVRP_ASSERT_NOW(a_msg_only, o_out_valid && o_msg_len != 32'd0, o_reply_type == kvrp_pkg::RT_SERVER_ERR || o_reply_type == kvrp_pkg::RT_CLIENT_ERR, "message on non-error item")

endmodule

bind kv_text_reply_parser_unit kvrp_checker u_kvrp_checker (.*);
